// ===== hdl/dcp_pkg.sv =====
// Shared types, constants and the dither function of the chunky-to-planar converter.
`timescale 1ns / 1ps
`default_nettype none

package dcp_pkg;

    // Item kinds carried in bit 0 of the input tuser.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam int LUM_W  = 10;
    localparam int WORD_W = 32;

    typedef logic [LUM_W-1:0]  lum_t;
    typedef logic [WORD_W-1:0] word_t;

    // 4x4 Bayer matrix, indexed by {row, column}.
    localparam logic [3:0] BAYER [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    localparam lum_t LUM_255 = 10'd255;
    localparam lum_t LUM_256 = 10'd256;
    localparam lum_t LUM_511 = 10'd511;
    localparam lum_t LUM_512 = 10'd512;
    localparam lum_t LUM_767 = 10'd767;

    // Bits that one input pixel at group slot pos adds to the planar word.
    function automatic word_t pixel_bits(input lum_t lum, input logic [1:0] phase,
                                         input logic [2:0] pos);
        lum_t        cum0;
        lum_t        cum1;
        lum_t        cum2;
        lum_t        thr;
        logic [1:0]  grey;
        logic [3:0]  opx;
        word_t       bits;
        begin
            bits = '0;
            // Cumulative grey weights collapse to a few simple ranges of lum.
            if (lum < LUM_256)
            begin
                cum0 = LUM_255 - lum;
                cum1 = LUM_255;
                cum2 = LUM_255;
            end
            else if (lum < LUM_512)
            begin
                cum0 = '0;
                cum1 = LUM_511 - lum;
                cum2 = LUM_255;
            end
            else
            begin
                cum0 = '0;
                cum1 = '0;
                cum2 = (lum < LUM_767) ? (LUM_767 - lum) : '0;
            end
            for (int j = 0; j < 2; j++)
            begin
                opx  = {pos, 1'(j)};
                thr  = {2'b00, BAYER[{phase, opx[1:0]}], 4'd7};
                if (cum0 >= thr)
                    grey = 2'd0;
                else if (cum1 >= thr)
                    grey = 2'd1;
                else if (cum2 >= thr)
                    grey = 2'd2;
                else
                    grey = 2'd3;
                bits[5'd31 - 5'(opx)] = grey[0];
                bits[5'd15 - 5'(opx)] = grey[1];
            end
            return bits;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dcp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dcp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/dithered_chunky_to_planar_top.sv =====
// Top level of the dithered chunky-to-planar converter.
//
//  channel  dir  tdata bits                                          tuser bits
//  s_*      in   color_index[7:0] red[15:8] green[23:16] blue[31:24]  req_type[0]
//                dither_phase[33:32], zero pad [39:34]                row_start[1]
//  m_*      out  planar_word[31:0]                                   -
//
// An in-range load word writes the brightness store in the cycle it is accepted.
// A pixel word reads the store, then passes through the dither stage;
// one word per cycle is accepted as long as the output register can drain.
// The input stalls only when a finished planar word still waits in the output
// register and the dither stage holds the last pixel of the next group.
// Reset clears the group position, accumulator and valids; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dithered_chunky_to_planar_top
    import dcp_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // color_index, red, green, blue, dither_phase
    input  wire logic [1:0]  s_tuser,   // req_type, row_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // planar_word
);

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [7:0]  color_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  dither_phase;
    logic        req_type;
    logic        row_start;
    logic        in_range;
    logic        accept;
    logic        load_en;
    logic        pixel_en;
    lum_t        sum;
    lum_t        ram_rd;
    lum_t        lum;

    logic        s1_valid_reg;
    logic [1:0]  s1_phase_reg;
    logic        s1_start_reg;
    logic        s1_hit_reg;
    word_t       acc_reg;
    word_t       acc_next;
    logic [2:0]  grp_reg;
    logic [2:0]  pos;
    logic        last;
    logic        s1_adv;
    logic        m_valid_reg;
    word_t       m_data_reg;

    assign color_index  = s_tdata[7:0];
    assign red          = s_tdata[15:8];
    assign green        = s_tdata[23:16];
    assign blue         = s_tdata[31:24];
    assign dither_phase = s_tdata[33:32];
    assign req_type     = s_tuser[0];
    assign row_start    = s_tuser[1];

    assign in_range = 9'(color_index) < 9'(PALETTE_ENTRIES);
    assign accept   = s_tvalid && s_tready;
    assign load_en  = accept && (req_type == REQ_LOAD) && in_range;
    assign pixel_en = accept && (req_type == REQ_PIXEL);
    assign sum      = 10'(red) + 10'(green) + 10'(blue);

    dcp_ram #(
        .WIDTH (LUM_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (color_index[ADDR_W-1:0]),
        .wr_data (sum),
        .rd_en   (pixel_en),
        .rd_addr (color_index[ADDR_W-1:0]),
        .rd_data (ram_rd)
    );

    // Dither stage: the read data arrives in the cycle after the pixel is accepted.
    always_comb
    begin
        lum      = s1_hit_reg ? ram_rd : '0;
        pos      = s1_start_reg ? 3'd0 : grp_reg;
        acc_next = (s1_start_reg ? '0 : acc_reg) | pixel_bits(lum, s1_phase_reg, pos);
        last     = (pos == 3'd7);
        s1_adv   = s1_valid_reg && (!last || !m_valid_reg || m_tready);
    end

    assign s_tready = !s1_valid_reg || s1_adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            grp_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_adv || !s1_valid_reg)
                s1_valid_reg <= pixel_en;
            if (s1_adv && last)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                if (last)
                begin
                    acc_reg <= '0;
                    grp_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_next;
                    grp_reg <= pos + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_en)
        begin
            s1_phase_reg <= dither_phase;
            s1_start_reg <= row_start;
            s1_hit_reg   <= in_range;
        end
        if (s1_adv && last)
            m_data_reg <= acc_next;
    end

    // The input only stalls behind a held pixel that must emit into a full output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_valid_reg && last))
        else $error("input stalled without a blocked emission");

    // Completing a group empties the accumulator and presents the word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && last) |=> (acc_reg == '0 && grp_reg == 3'd0 && m_valid_reg))
        else $error("group completion did not restart the accumulator");

    // A waiting output word is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("pending output word lost");

    // The dither stage never holds a pixel it has not been handed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !pixel_en) |=> !s1_valid_reg)
        else $error("dither stage became valid without a pixel");

endmodule

`default_nettype wire

// ===== tb/dithered_chunky_to_planar_top_tb.sv =====
// Self-checking testbench for the dithered chunky-to-planar converter.
`timescale 1ns / 1ps

module dithered_chunky_to_planar_top_tb;
    import dcp_pkg::*;

    localparam int RANDOM_ITEMS = 1627;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;

    localparam int DITHER_ROWS [4][4] = '{
        '{0, 8, 2, 10},
        '{12, 4, 14, 6},
        '{3, 11, 1, 9},
        '{15, 7, 13, 5}
    };

    typedef struct packed {
        logic       req;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] phase;
        logic       row_start;
    } chunky_item_t;

    typedef struct packed {
        chunky_item_t item;
        logic         check;
        word_t        want;
    } directed_row_t;

    // Loads at brightness extremes and a range edge, a full white group with a load
    // in the middle, a partial group thrown away by a row start, then a black group.
    localparam directed_row_t DIRECTED [23] = '{
        '{'{REQ_LOAD,  8'h00, 8'h00, 8'h00, 8'h00, 2'd3, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_LOAD,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd0, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_LOAD,  8'hAA, 8'h55, 8'hAA, 8'h00, 2'd1, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd0, 1'b1}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd1, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd2, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd3, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_LOAD,  8'h55, 8'h01, 8'hFF, 8'h00, 2'd3, 1'b1}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd1, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd2, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd3, 1'b0}, 1'b1, 32'hFFFF_FFFF},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd1, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd2, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd3, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 1'b1}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 2'd1, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 2'd2, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 2'd3, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 2'd1, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 2'd2, 1'b0}, 1'b0, 32'h0},
        '{'{REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 2'd3, 1'b0}, 1'b1, 32'h0000_0000}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // Predictor state: brightness per palette entry and the group being assembled.
    lum_t        bright_copy [256];
    bit          entry_loaded [256];
    logic [7:0]  loaded_list [$];
    word_t       group_word;
    logic [2:0]  group_slot;
    word_t       planar_expect_q [$];

    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;
    bit          hold_done;
    int          mismatches;
    int          words_checked;
    int          loads_sent;
    int          pixels_sent;
    int          row_starts_sent;
    int          cycle_count;
    word_t       oldest_word;

    dithered_chunky_to_planar_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bits that one pixel of brightness lum adds at group slot `slot`.
    function automatic word_t dither_slot_bits(input lum_t lum, input logic [1:0] phase,
                                               input logic [2:0] slot);
        int    l;
        int    w0;
        int    w1;
        int    w2;
        int    w3;
        int    cum [3];
        int    thr;
        int    grey;
        int    opx;
        word_t bits;
        begin
            l    = int'(lum);
            bits = '0;
            w0 = (l < 256) ? 255 - l : 0;
            w1 = (l < 256) ? l : ((l < 512) ? 511 - l : 0);
            w2 = (l < 256) ? 0 : ((l < 512) ? l - 256 : ((l < 767) ? 767 - l : 0));
            w3 = (l < 512) ? 0 : l - 512;
            cum[0] = w0;
            cum[1] = w0 + w1;
            cum[2] = w0 + w1 + w2;
            if (w3 < 0)
                bits = '0;
            for (int n = 0; n < 2; n++)
            begin
                opx  = 2 * int'(slot) + n;
                thr  = DITHER_ROWS[phase][opx % 4] * 16 + 7;
                grey = 3;
                // Walk down so that the lowest grey that reaches the threshold wins.
                for (int k = 2; k >= 0; k--)
                begin
                    if (cum[k] >= thr)
                        grey = k;
                end
                if ((grey & 1) != 0)
                    bits[31 - opx] = 1'b1;
                if ((grey & 2) != 0)
                    bits[15 - opx] = 1'b1;
            end
            return bits;
        end
    endfunction

    task automatic apply_item(input chunky_item_t it, output bit done, output word_t w);
        begin
            done = 1'b0;
            w    = '0;
            if (it.req == REQ_LOAD)
            begin
                bright_copy[it.idx] = 10'(it.red) + 10'(it.green) + 10'(it.blue);
                if (!entry_loaded[it.idx])
                    loaded_list.push_back(it.idx);
                entry_loaded[it.idx] = 1'b1;
                loads_sent++;
            end
            else
            begin
                pixels_sent++;
                if (it.row_start)
                begin
                    row_starts_sent++;
                    group_word = '0;
                    group_slot = '0;
                end
                group_word |= dither_slot_bits(bright_copy[it.idx], it.phase, group_slot);
                if (group_slot == 3'd7)
                begin
                    done       = 1'b1;
                    w          = group_word;
                    group_word = '0;
                end
                group_slot = group_slot + 3'd1;
            end
        end
    endtask

    // Offers one word and returns at the rising edge that accepts it.
    task automatic offer_item(input chunky_item_t it);
        begin
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {6'b0, it.phase, it.blue, it.green, it.red, it.idx};
            s_tuser  <= {it.row_start, it.req};
            forever
            begin
                @(posedge clk);
                if (s_tready)
                    break;
                @(negedge clk);
            end
        end
    endtask

    // Splits a brightness target into three components of 0..255.
    task automatic split_brightness(input int target, output logic [7:0] r,
                                    output logic [7:0] g, output logic [7:0] b);
        int rv;
        int rest;
        int gv;
        begin
            rv   = $urandom_range((target < 255) ? target : 255,
                                  (target > 510) ? target - 510 : 0);
            rest = target - rv;
            gv   = $urandom_range((rest < 255) ? rest : 255, (rest > 255) ? rest - 255 : 0);
            r    = 8'(rv);
            g    = 8'(gv);
            b    = 8'(rest - gv);
        end
    endtask

    task automatic random_item(output chunky_item_t it);
        int target;
        begin
            it.idx       = 8'($urandom_range(255));
            it.phase     = 2'($urandom_range(3));
            it.row_start = ($urandom_range(99) < 5);
            it.red       = 8'($urandom_range(255));
            it.green     = 8'($urandom_range(255));
            it.blue      = 8'($urandom_range(255));
            if ($urandom_range(99) < 15)
            begin
                it.req = REQ_LOAD;
                case ($urandom_range(9))
                    0: target = 0;
                    1: target = 255;
                    2: target = 256;
                    3: target = 511;
                    4: target = 512;
                    5: target = 765;
                    6: target = $urandom_range(700, 765);
                    default: target = $urandom_range(765);
                endcase
                split_brightness(target, it.red, it.green, it.blue);
            end
            else
            begin
                // Pixels only ever name entries that have been loaded.
                it.req = REQ_PIXEL;
                it.idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
            end
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && words_checked >= 40)
            begin
                // Long back-pressure so the converter fills up and stalls its input.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (planar_expect_q.size() == 0)
            begin
                $error("planar_word: unexpected word %h", m_tdata);
                mismatches++;
            end
            else
            begin
                oldest_word = planar_expect_q.pop_front();
                words_checked++;
                if (m_tdata !== oldest_word)
                begin
                    $error("planar_word: expected %h, actual %h", oldest_word, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycle_count, planar_expect_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        chunky_item_t it;
        bit           done;
        word_t        w;

        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        group_word      = '0;
        group_slot      = '0;
        send_idle_pct   = 21;
        recv_idle_pct   = 71;
        hold_left       = 0;
        hold_done       = 1'b0;
        mismatches      = 0;
        words_checked   = 0;
        loads_sent      = 0;
        pixels_sent     = 0;
        row_starts_sent = 0;
        cycle_count     = 0;
        for (int i = 0; i < 256; i++)
        begin
            bright_copy[i]  = '0;
            entry_loaded[i] = 1'b0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
        begin
            offer_item(DIRECTED[i].item);
            apply_item(DIRECTED[i].item, done, w);
            if (done)
                planar_expect_q.push_back(DIRECTED[i].check ? DIRECTED[i].want : w);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 21;
            end
            else if (i == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_item(it);
            offer_item(it);
            apply_item(it, done, w);
            if (done)
                planar_expect_q.push_back(w);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (planar_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d palette loads and %0d pixels (%0d row starts) through all idle mixes",
                 loads_sent, pixels_sent, row_starts_sent);
        $display("Checked %0d planar words, including a %0d-cycle output stall",
                 words_checked, HOLD_CYCLES);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dcp_pkg.sv
hdl/dcp_ram.sv
hdl/dithered_chunky_to_planar_top.sv
tb/dithered_chunky_to_planar_top_tb.sv
